// ===== rtl/ila_pkg.sv =====
// ----------------------------------------------------------------------------
// ila_pkg
// Shared types and constants for the first-fit boundary-tag heap allocator:
// field widths, request and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package ila_pkg;

  // payload field widths
  localparam int MODE_W   = 1;
  localparam int REQ_W    = 17;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 17;

  // parameter defaults
  localparam int HEAP_BYTES_DEF = 65536;
  localparam int INIT_CHUNK_DEF = 4096;

  // heap layout constants
  localparam int FIRST_PAYLOAD = 8;
  localparam int MIN_SPLIT     = 16;
  localparam int LIMIT_RESET   = 65536;

  // request codes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_INIT_P0,
    S_INIT_P1,
    S_INIT_H,
    S_INIT_F,
    S_INIT_E,
    S_IDLE,
    S_FIT_RD,
    S_FIT_CHK,
    S_MISS,
    S_GROW_F,
    S_GROW_E,
    S_MRG_RP,
    S_MRG_RN,
    S_MRG_CN,
    S_MRG_WH,
    S_MRG_WF,
    S_TAKE_H,
    S_TAKE_F,
    S_TAKE_H2,
    S_TAKE_F2,
    S_LV_RD,
    S_LV_CHK,
    S_FR_H,
    S_FR_F,
    S_RESP
  } ila_state_t;

endpackage

// ===== rtl/ila_if.sv =====
// ----------------------------------------------------------------------------
// ila channel interfaces
// Valid/ready channels for requests, results and the heap limit register.
// ----------------------------------------------------------------------------
interface ila_req_if;
  logic                          valid;
  logic                          ready;
  logic [ila_pkg::MODE_W-1:0]    mode;
  logic [ila_pkg::REQ_W-1:0]     request_size;
  logic [ila_pkg::ADDR_W-1:0]    block_addr;
  modport source (output valid, mode, request_size, block_addr, input ready);
  modport sink   (input valid, mode, request_size, block_addr, output ready);
endinterface

interface ila_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ila_pkg::ADDR_W-1:0]    result_addr;
  logic [ila_pkg::STATUS_W-1:0]  status;
  modport source (output valid, result_addr, status, input ready);
  modport sink   (input valid, result_addr, status, output ready);
endinterface

interface ila_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ila_pkg::LIMIT_W-1:0]   heap_limit_bytes;
  modport source (output valid, heap_limit_bytes, input ready);
  modport sink   (input valid, heap_limit_bytes, output ready);
endinterface

// ===== rtl/implicit_list_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator
// Heap allocator over an internal word memory with header/footer size tags:
// first-fit walk, split, growth at the top and coalescing on free and after growth.
// ----------------------------------------------------------------------------
//  channel   dir  transfer carries
//  in_ch     in   mode, request_size, block_addr
//  out_ch    out  result_addr, status (one per request)
//  cfg_ch    in   heap_limit_bytes (always ready)
//
// one memory access per cycle on a single-port word memory with a registered read;
// an allocate walks the blocks, then ends the walk and, where needed, grows,
// merges, splits and returns its result; a free walks the blocks up to it,
// clears its tags, merges and returns its result.
// after reset the heap layout is written before requests are taken.
// a request is taken while an earlier result still waits on out_ch.
module implicit_list_first_fit_allocator #(
  parameter int HEAP_BYTES = ila_pkg::HEAP_BYTES_DEF,
  parameter int INIT_CHUNK = ila_pkg::INIT_CHUNK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ila_req_if.sink     in_ch,
  ila_rsp_if.source   out_ch,
  ila_cfg_if.sink     cfg_ch
);

  localparam int NWORDS    = HEAP_BYTES / 4;
  localparam int IW        = $clog2(NWORDS);
  localparam int AW        = ($clog2(HEAP_BYTES) + 2 > 19) ? $clog2(HEAP_BYTES) + 2 : 19;
  localparam int CHUNK_RND = ((INIT_CHUNK + 7) / 8) * 8;
  localparam int ROOM      = ((HEAP_BYTES - 16) / 8) * 8;
  localparam int CHUNK     = (CHUNK_RND > ROOM) ? ROOM : CHUNK_RND;
  localparam int INIT_TOP  = 16 + CHUNK;

  ila_pkg::ila_state_t state_r, state_nxt;

  logic [AW-1:0] bp_r, bp_nxt;
  logic [AW-1:0] csize_r, csize_nxt;
  logic [AW-1:0] asize_r, asize_nxt;
  logic [AW-1:0] pf_size_r, pf_size_nxt;
  logic          pf_free_r, pf_free_nxt;
  logic [AW-1:0] top_r, top_nxt;
  logic [ila_pkg::LIMIT_W-1:0] limit_r;
  logic [ila_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [ila_pkg::ADDR_W-1:0]  faddr_r, faddr_nxt;
  logic [ila_pkg::ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic [ila_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ila_pkg::ADDR_W-1:0]  out_addr_r;
  logic [ila_pkg::STATUS_W-1:0] out_status_r;

  // word memory
  logic [31:0]   mem [NWORDS];
  logic [31:0]   mem_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;

  // shared conditions
  logic          in_xfer, out_free, split;
  logic [AW-1:0] hdr_size, ntop, bound, take_sz, req_asize, addr_ext, total;
  logic          hdr_alloc;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign hdr_size  = AW'(mem_q) & ~AW'(7);
  assign hdr_alloc = mem_q[0];
  assign ntop      = top_r + asize_r;
  assign bound     = (AW'(limit_r) < AW'(HEAP_BYTES)) ? AW'(limit_r) : AW'(HEAP_BYTES);
  assign split     = (csize_r - asize_r) >= AW'(ila_pkg::MIN_SPLIT);
  assign take_sz   = split ? asize_r : csize_r;
  assign req_asize = (AW'(in_ch.request_size) + AW'(15)) & ~AW'(7);
  assign addr_ext  = AW'(faddr_r);
  assign total     = csize_r + (hdr_alloc ? '0 : hdr_size) + (pf_free_r ? pf_size_r : '0);

  // channel handshakes
  assign in_ch.ready        = (state_r == ila_pkg::S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_addr = out_addr_r;
  assign out_ch.status      = out_status_r;

  // memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr[IW+1:2]] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr[IW+1:2]];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ila_pkg::S_INIT_P0: state_nxt = ila_pkg::S_INIT_P1;
      ila_pkg::S_INIT_P1: state_nxt = ila_pkg::S_INIT_H;
      ila_pkg::S_INIT_H:  state_nxt = ila_pkg::S_INIT_F;
      ila_pkg::S_INIT_F:  state_nxt = ila_pkg::S_INIT_E;
      ila_pkg::S_INIT_E:  state_nxt = ila_pkg::S_IDLE;
      ila_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.mode == ila_pkg::MODE_ALLOC) begin
            state_nxt = (in_ch.request_size == '0) ? ila_pkg::S_RESP : ila_pkg::S_FIT_RD;
          end else begin
            state_nxt = (in_ch.block_addr == '0) ? ila_pkg::S_RESP : ila_pkg::S_LV_RD;
          end
        end
      end
      ila_pkg::S_FIT_RD: state_nxt = (bp_r >= top_r) ? ila_pkg::S_MISS : ila_pkg::S_FIT_CHK;
      ila_pkg::S_FIT_CHK: begin
        if (hdr_size == '0) begin
          state_nxt = ila_pkg::S_MISS;
        end else if (!hdr_alloc && asize_r <= hdr_size) begin
          state_nxt = ila_pkg::S_TAKE_H;
        end else begin
          state_nxt = ila_pkg::S_FIT_RD;
        end
      end
      ila_pkg::S_MISS:   state_nxt = (ntop > bound) ? ila_pkg::S_RESP : ila_pkg::S_GROW_F;
      ila_pkg::S_GROW_F: state_nxt = ila_pkg::S_GROW_E;
      ila_pkg::S_GROW_E: state_nxt = ila_pkg::S_MRG_RP;
      ila_pkg::S_MRG_RP: state_nxt = ila_pkg::S_MRG_RN;
      ila_pkg::S_MRG_RN: state_nxt = ila_pkg::S_MRG_CN;
      ila_pkg::S_MRG_CN: state_nxt = ila_pkg::S_MRG_WH;
      ila_pkg::S_MRG_WH: state_nxt = ila_pkg::S_MRG_WF;
      ila_pkg::S_MRG_WF: begin
        state_nxt = (mode_r == ila_pkg::MODE_ALLOC) ? ila_pkg::S_TAKE_H : ila_pkg::S_RESP;
      end
      ila_pkg::S_TAKE_H:  state_nxt = ila_pkg::S_TAKE_F;
      ila_pkg::S_TAKE_F:  state_nxt = split ? ila_pkg::S_TAKE_H2 : ila_pkg::S_RESP;
      ila_pkg::S_TAKE_H2: state_nxt = ila_pkg::S_TAKE_F2;
      ila_pkg::S_TAKE_F2: state_nxt = ila_pkg::S_RESP;
      ila_pkg::S_LV_RD:  state_nxt = (bp_r >= top_r) ? ila_pkg::S_RESP : ila_pkg::S_LV_CHK;
      ila_pkg::S_LV_CHK: begin
        if (hdr_size == '0) begin
          state_nxt = ila_pkg::S_RESP;
        end else if (bp_r == addr_ext) begin
          state_nxt = (bp_r != AW'(ila_pkg::FIRST_PAYLOAD) && hdr_alloc) ?
                      ila_pkg::S_FR_H : ila_pkg::S_RESP;
        end else if (bp_r > addr_ext) begin
          state_nxt = ila_pkg::S_RESP;
        end else begin
          state_nxt = ila_pkg::S_LV_RD;
        end
      end
      ila_pkg::S_FR_H: state_nxt = ila_pkg::S_FR_F;
      ila_pkg::S_FR_F: state_nxt = ila_pkg::S_MRG_RP;
      ila_pkg::S_RESP: state_nxt = out_free ? ila_pkg::S_IDLE : ila_pkg::S_RESP;
      default:         state_nxt = ila_pkg::S_IDLE;
    endcase
  end

  // memory accesses
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = bp_r - AW'(4);
    mem_wdata = '0;
    case (state_r)
      ila_pkg::S_INIT_P0: begin
        mem_we = 1'b1; mem_addr = AW'(4); mem_wdata = 32'd9;
      end
      ila_pkg::S_INIT_P1: begin
        mem_we = 1'b1; mem_addr = AW'(8); mem_wdata = 32'd9;
      end
      ila_pkg::S_INIT_H: begin
        mem_we = 1'b1; mem_addr = AW'(12); mem_wdata = 32'(CHUNK);
      end
      ila_pkg::S_INIT_F: begin
        mem_we = 1'b1; mem_addr = AW'(INIT_TOP - 8); mem_wdata = 32'(CHUNK);
      end
      ila_pkg::S_INIT_E: begin
        mem_we = 1'b1; mem_addr = AW'(INIT_TOP - 4); mem_wdata = 32'd1;
      end
      ila_pkg::S_FIT_RD, ila_pkg::S_LV_RD: begin
        mem_re = (bp_r < top_r);
      end
      // grow: header at old epilogue, footer, new epilogue
      ila_pkg::S_MISS: begin
        mem_we = (ntop <= bound); mem_addr = top_r - AW'(4); mem_wdata = 32'(asize_r);
      end
      ila_pkg::S_GROW_F: begin
        mem_we = 1'b1; mem_addr = bp_r + asize_r - AW'(8); mem_wdata = 32'(asize_r);
      end
      ila_pkg::S_GROW_E: begin
        mem_we = 1'b1; mem_addr = bp_r + asize_r - AW'(4); mem_wdata = 32'd1;
      end
      // merge: previous footer then next header
      ila_pkg::S_MRG_RP: begin
        mem_re = 1'b1; mem_addr = bp_r - AW'(8);
      end
      ila_pkg::S_MRG_RN: begin
        mem_re = 1'b1; mem_addr = bp_r + csize_r - AW'(4);
      end
      ila_pkg::S_MRG_WH: begin
        mem_we = 1'b1; mem_addr = bp_r - AW'(4); mem_wdata = 32'(csize_r);
      end
      ila_pkg::S_MRG_WF: begin
        mem_we = 1'b1; mem_addr = bp_r + csize_r - AW'(8); mem_wdata = 32'(csize_r);
      end
      // place: allocated part, then free remainder on a split
      ila_pkg::S_TAKE_H: begin
        mem_we = 1'b1; mem_addr = bp_r - AW'(4); mem_wdata = 32'(take_sz) | 32'd1;
      end
      ila_pkg::S_TAKE_F: begin
        mem_we = 1'b1; mem_addr = bp_r + take_sz - AW'(8); mem_wdata = 32'(take_sz) | 32'd1;
      end
      ila_pkg::S_TAKE_H2: begin
        mem_we = 1'b1; mem_addr = bp_r + asize_r - AW'(4);
        mem_wdata = 32'(csize_r - asize_r);
      end
      ila_pkg::S_TAKE_F2: begin
        mem_we = 1'b1; mem_addr = bp_r + csize_r - AW'(8);
        mem_wdata = 32'(csize_r - asize_r);
      end
      // free: clear the allocated bit in both tags
      ila_pkg::S_FR_H: begin
        mem_we = 1'b1; mem_addr = bp_r - AW'(4); mem_wdata = 32'(csize_r);
      end
      ila_pkg::S_FR_F: begin
        mem_we = 1'b1; mem_addr = bp_r + csize_r - AW'(8); mem_wdata = 32'(csize_r);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    bp_nxt         = bp_r;
    csize_nxt      = csize_r;
    asize_nxt      = asize_r;
    pf_size_nxt    = pf_size_r;
    pf_free_nxt    = pf_free_r;
    top_nxt        = top_r;
    mode_nxt       = mode_r;
    faddr_nxt      = faddr_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    case (state_r)
      ila_pkg::S_IDLE: begin
        if (in_xfer) begin
          mode_nxt       = in_ch.mode;
          faddr_nxt      = in_ch.block_addr;
          asize_nxt      = req_asize;
          bp_nxt         = AW'(ila_pkg::FIRST_PAYLOAD);
          res_addr_nxt   = '0;
          res_status_nxt = ila_pkg::ST_IGNORED;
        end
      end
      ila_pkg::S_FIT_CHK: begin
        if (hdr_size != '0) begin
          if (!hdr_alloc && asize_r <= hdr_size) begin
            csize_nxt = hdr_size;
          end else begin
            bp_nxt = bp_r + hdr_size;
          end
        end
      end
      ila_pkg::S_MISS: begin
        if (ntop > bound) begin
          res_status_nxt = ila_pkg::ST_NOSPACE;
        end else begin
          bp_nxt    = top_r;
          csize_nxt = asize_r;
        end
      end
      ila_pkg::S_GROW_E: begin
        top_nxt = bp_r + asize_r;
      end
      ila_pkg::S_MRG_RN: begin
        pf_size_nxt = hdr_size;
        pf_free_nxt = !hdr_alloc;
      end
      ila_pkg::S_MRG_CN: begin
        csize_nxt = total;
        bp_nxt    = pf_free_r ? bp_r - pf_size_r : bp_r;
      end
      ila_pkg::S_MRG_WF: begin
        if (mode_r != ila_pkg::MODE_ALLOC) begin
          res_status_nxt = ila_pkg::ST_DONE;
        end
      end
      ila_pkg::S_TAKE_F, ila_pkg::S_TAKE_F2: begin
        res_addr_nxt   = bp_r[ila_pkg::ADDR_W-1:0];
        res_status_nxt = ila_pkg::ST_DONE;
      end
      ila_pkg::S_LV_CHK: begin
        if (hdr_size != '0 && bp_r < addr_ext) begin
          bp_nxt = bp_r + hdr_size;
        end
        csize_nxt = hdr_size;
      end
      default: begin
        bp_nxt = bp_r;
      end
    endcase
  end

  // result register: loads when the held result is gone or leaving
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (state_r == ila_pkg::S_RESP && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ila_pkg::S_INIT_P0;
      top_r       <= AW'(INIT_TOP);
      limit_r     <= ila_pkg::LIMIT_W'(ila_pkg::LIMIT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.heap_limit_bytes;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bp_r         <= bp_nxt;
    csize_r      <= csize_nxt;
    asize_r      <= asize_nxt;
    pf_size_r    <= pf_size_nxt;
    pf_free_r    <= pf_free_nxt;
    mode_r       <= mode_nxt;
    faddr_r      <= faddr_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == ila_pkg::S_RESP && out_free) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

endmodule
